/* design/mpq_pkg.sv */
// shared types, constants and reset-value helpers for the message pool queue manager
// no dependencies
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int POOL_SIZE    = 64;
    localparam int QUEUE_COUNT  = 16;
    localparam int SENDER_BITS  = 5;
    localparam int PAYLOAD_BITS = 32;

    localparam int CMD_W  = 4;
    localparam int QID_W  = 4;
    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int LINK_W = IDX_W + 1;
    localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

    localparam logic [CMD_W-1:0] CMD_ALLOC    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PUSH     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_POP      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_ISEMPTY  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MKEMPTY  = 4'd7;

    typedef enum logic [3:0] {
        OP_ALLOC, OP_FREE, OP_INSERT, OP_PUSH, OP_PEEK,
        OP_POP, OP_ISEMPTY, OP_MKEMPTY, OP_NOP, OP_FAIL
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_SRCH, ST_SRCH_W, ST_PEEK_W, ST_UL_RD, ST_UL_W,
        ST_UL1, ST_UL2, ST_LT1, ST_LT2, ST_LH1, ST_LH2, ST_DONE
    } t_state;

    typedef struct packed {
        t_op                     op;
        logic                    qok;
        logic [QIDX_W-1:0]       q;
        logic [IDX_W-1:0]        m;
        logic [SENDER_BITS-1:0]  snd;
        logic [PAYLOAD_BITS-1:0] pay;
        logic [SENDER_BITS-1:0]  key;
    } t_cmd;

    typedef struct packed {
        logic                    valid;
        logic                    status;
        logic [IDX_W-1:0]        idx;
        logic [SENDER_BITS-1:0]  snd;
        logic [PAYLOAD_BITS-1:0] pay;
        logic                    qempty;
    } t_res;

    // link contents of an entry never written: the free list in index order
    function automatic logic [LINK_W-1:0] rst_next(input logic [IDX_W-1:0] a);
        return LINK_W'(a) + LINK_W'(1);
    endfunction

    function automatic logic [LINK_W-1:0] rst_prev(input logic [IDX_W-1:0] a);
        return (a == '0) ? NIL : (LINK_W'(a) - LINK_W'(1));
    endfunction

endpackage

/* design/mpq_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/mpq_front.sv */
// command front end: range checks, classification and a two-word command queue
// depends on mpq_pkg
`timescale 1ns / 1ps

module mpq_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mpq_pkg::CMD_W-1:0]       i_command,
    input  logic [mpq_pkg::QID_W-1:0]       i_queue_id,
    input  logic [mpq_pkg::IDX_W-1:0]       i_msg_index,
    input  logic [mpq_pkg::SENDER_BITS-1:0] i_sender,
    input  logic [mpq_pkg::PAYLOAD_BITS-1:0] i_payload,
    input  logic [mpq_pkg::SENDER_BITS-1:0] i_sender_key,
    input  logic                            i_pop,
    output logic                            o_cmd_valid,
    output mpq_pkg::t_cmd                   o_cmd
);

    mpq_pkg::t_cmd r_slot [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;
    mpq_pkg::t_cmd cls;
    logic          qok, iok, push;

    always_comb begin
        qok = 32'(i_queue_id) < mpq_pkg::QUEUE_COUNT;
        iok = 32'(i_msg_index) < mpq_pkg::POOL_SIZE;
        cls.qok = qok;
        cls.q   = qok ? mpq_pkg::QIDX_W'(i_queue_id) : '0;
        cls.m   = i_msg_index;
        cls.snd = i_sender;
        cls.pay = i_payload;
        cls.key = i_sender_key;
        unique case (i_command)
            mpq_pkg::CMD_ALLOC:   cls.op = mpq_pkg::OP_ALLOC;
            mpq_pkg::CMD_FREE:    cls.op = iok ? mpq_pkg::OP_FREE : mpq_pkg::OP_FAIL;
            mpq_pkg::CMD_INSERT:  cls.op = (qok && iok) ? mpq_pkg::OP_INSERT : mpq_pkg::OP_FAIL;
            mpq_pkg::CMD_PUSH:    cls.op = (qok && iok) ? mpq_pkg::OP_PUSH : mpq_pkg::OP_FAIL;
            mpq_pkg::CMD_PEEK:    cls.op = qok ? mpq_pkg::OP_PEEK : mpq_pkg::OP_FAIL;
            mpq_pkg::CMD_POP:     cls.op = qok ? mpq_pkg::OP_POP : mpq_pkg::OP_FAIL;
            mpq_pkg::CMD_ISEMPTY: cls.op = qok ? mpq_pkg::OP_ISEMPTY : mpq_pkg::OP_FAIL;
            mpq_pkg::CMD_MKEMPTY: cls.op = qok ? mpq_pkg::OP_MKEMPTY : mpq_pkg::OP_FAIL;
            default:              cls.op = mpq_pkg::OP_NOP;
        endcase
    end

    assign busy        = (r_cnt == 2'd2);
    assign push        = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= cls;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

/* design/mpq_back.sv */
// command sequencer: link updates over the pool memories, sender search, result register
// depends on mpq_pkg and mpq_ram
`timescale 1ns / 1ps

module mpq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  mpq_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output mpq_pkg::t_res o_res
);

    localparam int IW = mpq_pkg::IDX_W;
    localparam int LW = mpq_pkg::LINK_W;
    localparam int SW = mpq_pkg::SENDER_BITS;
    localparam int PW = mpq_pkg::PAYLOAD_BITS;

    mpq_pkg::t_state r_state, n_state;
    mpq_pkg::t_cmd   r_cmd;

    logic [LW-1:0] r_qh [mpq_pkg::QUEUE_COUNT];
    logic [LW-1:0] r_qt [mpq_pkg::QUEUE_COUNT];
    logic [LW-1:0] r_fh, r_ft;
    logic [mpq_pkg::POOL_SIZE-1:0] r_vn, r_vp, r_vs;

    logic [LW-1:0] r_e, n_e, r_p, n_p, r_n, n_n, r_cur, n_cur, r_steps, n_steps;
    logic          r_status, n_status, r_have, n_have;
    logic [SW-1:0] r_osnd, n_osnd;
    logic [PW-1:0] r_opay, n_opay;
    mpq_pkg::t_res r_res;

    logic [IW-1:0] r_rd_addr, rd_addr;
    logic          r_rv_n, r_rv_p, r_rv_s;
    logic [LW-1:0] ram_next, ram_prev, eff_next, eff_prev;
    logic [SW-1:0] ram_snd, eff_snd;
    logic [PW-1:0] ram_pay, eff_pay;

    logic          nx_we, pv_we, sp_we;
    logic [IW-1:0] nx_wa, pv_wa, sp_wa;
    logic [LW-1:0] nx_wd, pv_wd;
    logic [SW-1:0] sd_wd;
    logic [PW-1:0] pl_wd;

    logic          h_we, t_we, use_free, is_alloc;
    logic [LW-1:0] h_val, t_val, l_h, l_t, qhead;

    assign use_free = (r_cmd.op == mpq_pkg::OP_ALLOC) || (r_cmd.op == mpq_pkg::OP_FREE);
    assign is_alloc = (r_cmd.op == mpq_pkg::OP_ALLOC);
    assign qhead    = r_qh[r_cmd.q];
    assign l_h      = use_free ? r_fh : qhead;
    assign l_t      = use_free ? r_ft : r_qt[r_cmd.q];

    // unwritten entries read as their reset contents
    assign eff_next = r_rv_n ? ram_next : mpq_pkg::rst_next(r_rd_addr);
    assign eff_prev = r_rv_p ? ram_prev : mpq_pkg::rst_prev(r_rd_addr);
    assign eff_snd  = r_rv_s ? ram_snd : '0;
    assign eff_pay  = r_rv_s ? ram_pay : '0;

    mpq_ram #(.WIDTH(LW), .DEPTH(mpq_pkg::POOL_SIZE)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(rd_addr), .o_rdata(ram_next)
    );
    mpq_ram #(.WIDTH(LW), .DEPTH(mpq_pkg::POOL_SIZE)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(rd_addr), .o_rdata(ram_prev)
    );
    mpq_ram #(.WIDTH(SW), .DEPTH(mpq_pkg::POOL_SIZE)) u_sender (
        .i_clk(i_clk), .i_we(sp_we), .i_waddr(sp_wa), .i_wdata(sd_wd),
        .i_raddr(rd_addr), .o_rdata(ram_snd)
    );
    mpq_ram #(.WIDTH(PW), .DEPTH(mpq_pkg::POOL_SIZE)) u_payload (
        .i_clk(i_clk), .i_we(sp_we), .i_waddr(sp_wa), .i_wdata(pl_wd),
        .i_raddr(rd_addr), .o_rdata(ram_pay)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpq_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = mpq_pkg::ST_DECODE;
                end
            end
            mpq_pkg::ST_DECODE: begin
                unique case (r_cmd.op)
                    mpq_pkg::OP_ALLOC:
                        n_state = (r_fh == mpq_pkg::NIL) ? mpq_pkg::ST_DONE : mpq_pkg::ST_UL_RD;
                    mpq_pkg::OP_FREE, mpq_pkg::OP_INSERT: n_state = mpq_pkg::ST_LT1;
                    mpq_pkg::OP_PUSH: n_state = mpq_pkg::ST_LH1;
                    mpq_pkg::OP_PEEK:
                        n_state = (qhead == mpq_pkg::NIL) ? mpq_pkg::ST_DONE : mpq_pkg::ST_PEEK_W;
                    mpq_pkg::OP_POP: begin
                        if (r_cmd.key != '0) begin
                            n_state = mpq_pkg::ST_SRCH;
                        end else begin
                            n_state = (qhead == mpq_pkg::NIL) ? mpq_pkg::ST_DONE
                                                              : mpq_pkg::ST_UL_RD;
                        end
                    end
                    default: n_state = mpq_pkg::ST_DONE;
                endcase
            end
            mpq_pkg::ST_SRCH: begin
                n_state = (r_cur == mpq_pkg::NIL || r_steps == LW'(mpq_pkg::POOL_SIZE))
                          ? mpq_pkg::ST_DONE : mpq_pkg::ST_SRCH_W;
            end
            mpq_pkg::ST_SRCH_W:
                n_state = (eff_snd == r_cmd.key) ? mpq_pkg::ST_UL_RD : mpq_pkg::ST_SRCH;
            mpq_pkg::ST_PEEK_W: n_state = mpq_pkg::ST_DONE;
            mpq_pkg::ST_UL_RD:  n_state = mpq_pkg::ST_UL_W;
            mpq_pkg::ST_UL_W:   n_state = mpq_pkg::ST_UL1;
            mpq_pkg::ST_UL1:    n_state = mpq_pkg::ST_UL2;
            mpq_pkg::ST_UL2:    n_state = mpq_pkg::ST_DONE;
            mpq_pkg::ST_LT1:
                n_state = (l_t != mpq_pkg::NIL) ? mpq_pkg::ST_LT2 : mpq_pkg::ST_DONE;
            mpq_pkg::ST_LH1:
                n_state = (l_h != mpq_pkg::NIL) ? mpq_pkg::ST_LH2 : mpq_pkg::ST_DONE;
            mpq_pkg::ST_LT2, mpq_pkg::ST_LH2: n_state = mpq_pkg::ST_DONE;
            mpq_pkg::ST_DONE:   n_state = mpq_pkg::ST_IDLE;
            default:            n_state = mpq_pkg::ST_IDLE;
        endcase
    end

    // datapath actions per state
    always_comb begin
        o_pop    = 1'b0;
        n_e      = r_e;
        n_p      = r_p;
        n_n      = r_n;
        n_cur    = r_cur;
        n_steps  = r_steps;
        n_status = r_status;
        n_have   = r_have;
        n_osnd   = r_osnd;
        n_opay   = r_opay;
        rd_addr  = r_e[IW-1:0];
        nx_we    = 1'b0;
        nx_wa    = r_cmd.m;
        nx_wd    = mpq_pkg::NIL;
        pv_we    = 1'b0;
        pv_wa    = r_cmd.m;
        pv_wd    = mpq_pkg::NIL;
        sp_we    = 1'b0;
        sp_wa    = r_cmd.m;
        sd_wd    = r_cmd.snd;
        pl_wd    = r_cmd.pay;
        h_we     = 1'b0;
        h_val    = mpq_pkg::NIL;
        t_we     = 1'b0;
        t_val    = mpq_pkg::NIL;
        unique case (r_state)
            mpq_pkg::ST_IDLE: begin
                o_pop    = i_cmd_valid;
                n_status = 1'b0;
                n_have   = 1'b0;
            end
            mpq_pkg::ST_DECODE: begin
                rd_addr = qhead[IW-1:0];
                unique case (r_cmd.op)
                    mpq_pkg::OP_ALLOC: begin
                        if (r_fh == mpq_pkg::NIL) begin
                            n_status = 1'b1;
                        end
                        n_e = r_fh;
                    end
                    mpq_pkg::OP_INSERT, mpq_pkg::OP_PUSH: sp_we = 1'b1;
                    mpq_pkg::OP_PEEK: begin
                        n_e = qhead;
                        if (qhead == mpq_pkg::NIL) begin
                            n_status = 1'b1;
                        end else begin
                            n_have = 1'b1;
                        end
                    end
                    mpq_pkg::OP_POP: begin
                        n_cur   = qhead;
                        n_steps = '0;
                        n_e     = qhead;
                        if (r_cmd.key == '0 && qhead == mpq_pkg::NIL) begin
                            n_status = 1'b1;
                        end
                    end
                    mpq_pkg::OP_MKEMPTY: begin
                        h_we = 1'b1;
                        t_we = 1'b1;
                    end
                    mpq_pkg::OP_FAIL: n_status = 1'b1;
                    default: ;
                endcase
            end
            mpq_pkg::ST_SRCH: begin
                rd_addr = r_cur[IW-1:0];
                if (r_cur == mpq_pkg::NIL || r_steps == LW'(mpq_pkg::POOL_SIZE)) begin
                    n_status = 1'b1;
                end
            end
            mpq_pkg::ST_SRCH_W: begin
                if (eff_snd == r_cmd.key) begin
                    n_e = r_cur;
                end else begin
                    n_cur   = eff_next;
                    n_steps = r_steps + LW'(1);
                end
            end
            mpq_pkg::ST_PEEK_W: begin
                n_osnd = eff_snd;
                n_opay = eff_pay;
            end
            mpq_pkg::ST_UL_RD: rd_addr = r_e[IW-1:0];
            mpq_pkg::ST_UL_W: begin
                n_p    = eff_prev;
                n_n    = eff_next;
                n_osnd = is_alloc ? '0 : eff_snd;
                n_opay = is_alloc ? '0 : eff_pay;
                n_have = 1'b1;
            end
            mpq_pkg::ST_UL1: begin
                if (r_p != mpq_pkg::NIL) begin
                    nx_we = 1'b1;
                    nx_wa = r_p[IW-1:0];
                    nx_wd = r_n;
                end else begin
                    h_we  = 1'b1;
                    h_val = r_n;
                end
                if (r_n != mpq_pkg::NIL) begin
                    pv_we = 1'b1;
                    pv_wa = r_n[IW-1:0];
                    pv_wd = r_p;
                end else begin
                    t_we  = 1'b1;
                    t_val = r_p;
                end
            end
            mpq_pkg::ST_UL2: begin
                nx_we = 1'b1;
                nx_wa = r_e[IW-1:0];
                pv_we = 1'b1;
                pv_wa = r_e[IW-1:0];
                // alloc hands out a cleared entry
                sp_we = is_alloc;
                sp_wa = r_e[IW-1:0];
                sd_wd = '0;
                pl_wd = '0;
            end
            mpq_pkg::ST_LT1: begin
                pv_we = 1'b1;
                pv_wd = l_t;
                nx_we = 1'b1;
                n_p   = l_t;
                if (l_t == mpq_pkg::NIL) begin
                    h_we  = 1'b1;
                    h_val = LW'(r_cmd.m);
                end
                t_we  = 1'b1;
                t_val = LW'(r_cmd.m);
            end
            mpq_pkg::ST_LT2: begin
                nx_we = 1'b1;
                nx_wa = r_p[IW-1:0];
                nx_wd = LW'(r_cmd.m);
            end
            mpq_pkg::ST_LH1: begin
                nx_we = 1'b1;
                nx_wd = l_h;
                pv_we = 1'b1;
                n_p   = l_h;
                if (l_h == mpq_pkg::NIL) begin
                    t_we  = 1'b1;
                    t_val = LW'(r_cmd.m);
                end
                h_we  = 1'b1;
                h_val = LW'(r_cmd.m);
            end
            mpq_pkg::ST_LH2: begin
                pv_we = 1'b1;
                pv_wa = r_p[IW-1:0];
                pv_wd = LW'(r_cmd.m);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_e       <= n_e;
        r_p       <= n_p;
        r_n       <= n_n;
        r_cur     <= n_cur;
        r_steps   <= n_steps;
        r_status  <= n_status;
        r_have    <= n_have;
        r_osnd    <= n_osnd;
        r_opay    <= n_opay;
        r_rd_addr <= rd_addr;
        r_rv_n    <= r_vn[rd_addr];
        r_rv_p    <= r_vp[rd_addr];
        r_rv_s    <= r_vs[rd_addr];
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == mpq_pkg::ST_DONE) begin
            r_res.status <= r_status;
            r_res.idx    <= r_have ? r_e[IW-1:0] : '0;
            r_res.snd    <= r_have ? r_osnd : '0;
            r_res.pay    <= r_have ? r_opay : '0;
            r_res.qempty <= !r_cmd.qok || (qhead == mpq_pkg::NIL);
        end
        if (!i_rst_n) begin
            r_state     <= mpq_pkg::ST_IDLE;
            r_res.valid <= 1'b0;
            r_vn        <= '0;
            r_vp        <= '0;
            r_vs        <= '0;
            r_fh        <= '0;
            r_ft        <= LW'(mpq_pkg::POOL_SIZE - 1);
            for (int i = 0; i < mpq_pkg::QUEUE_COUNT; i++) begin
                r_qh[i] <= mpq_pkg::NIL;
                r_qt[i] <= mpq_pkg::NIL;
            end
        end else begin
            r_state     <= n_state;
            r_res.valid <= (r_state == mpq_pkg::ST_DONE);
            if (nx_we) begin
                r_vn[nx_wa] <= 1'b1;
            end
            if (pv_we) begin
                r_vp[pv_wa] <= 1'b1;
            end
            if (sp_we) begin
                r_vs[sp_wa] <= 1'b1;
            end
            if (h_we) begin
                if (use_free) begin
                    r_fh <= h_val;
                end else begin
                    r_qh[r_cmd.q] <= h_val;
                end
            end
            if (t_we) begin
                if (use_free) begin
                    r_ft <= t_val;
                end else begin
                    r_qt[r_cmd.q] <= t_val;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

/* design/message_pool_queue_manager.sv */
// Message pool queue manager: one command per start pulse, one result word per command, in
// order, shown for a single cycle on o_valid; the receiver cannot stall. busy rises when the
// two-word command queue is full. Commands run one at a time in the sequencer; a pop that
// searches by sender reads the queue entries one at a time, up to 64 entries. No clearing
// pass after reset.
// depends on mpq_pkg, mpq_front, mpq_back
`timescale 1ns / 1ps

module message_pool_queue_manager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mpq_pkg::CMD_W-1:0]        i_command,
    input  logic [mpq_pkg::QID_W-1:0]        i_queue_id,
    input  logic [mpq_pkg::IDX_W-1:0]        i_msg_index,
    input  logic [mpq_pkg::SENDER_BITS-1:0]  i_sender,
    input  logic [mpq_pkg::PAYLOAD_BITS-1:0] i_payload,
    input  logic [mpq_pkg::SENDER_BITS-1:0]  i_sender_key,
    output logic                             o_valid,
    output logic                             o_status,
    output logic [mpq_pkg::IDX_W-1:0]        o_entry_index,
    output logic [mpq_pkg::SENDER_BITS-1:0]  o_entry_sender,
    output logic [mpq_pkg::PAYLOAD_BITS-1:0] o_entry_payload,
    output logic                             o_queue_empty
);

    mpq_pkg::t_cmd cmd;
    mpq_pkg::t_res res;
    logic          cmd_valid, cmd_pop;

    mpq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_queue_id(i_queue_id), .i_msg_index(i_msg_index),
        .i_sender(i_sender), .i_payload(i_payload), .i_sender_key(i_sender_key),
        .i_pop(cmd_pop), .o_cmd_valid(cmd_valid), .o_cmd(cmd)
    );

    mpq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_pop(cmd_pop), .o_res(res)
    );

    assign o_valid         = res.valid;
    assign o_status        = res.status;
    assign o_entry_index   = res.idx;
    assign o_entry_sender  = res.snd;
    assign o_entry_payload = res.pay;
    assign o_queue_empty   = res.qempty;

endmodule

/* design/mpq_checker.sv */
// port-level checks for the message pool queue manager, bound to the top level
// depends on mpq_pkg
`timescale 1ns / 1ps

module mpq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid,
    input logic                             o_status,
    input logic [mpq_pkg::IDX_W-1:0]        o_entry_index,
    input logic [mpq_pkg::SENDER_BITS-1:0]  o_entry_sender,
    input logic [mpq_pkg::PAYLOAD_BITS-1:0] o_entry_payload
);

    // a result word never follows another one directly
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result words");

    // a refused command carries no entry
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |->
            (o_entry_index == '0 && o_entry_sender == '0 && o_entry_payload == '0))
        else $error("failed command returned entry data");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("activity right after reset");

    // the queue cannot fill without an accepted word in the cycle before
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a new word");

endmodule

bind message_pool_queue_manager mpq_checker u_mpq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_valid(o_valid),
    .o_status(o_status), .o_entry_index(o_entry_index), .o_entry_sender(o_entry_sender),
    .o_entry_payload(o_entry_payload)
);
